[design/windowed_rms_current_meter_defines.svh]
// Assertion macros used by the RMS meter sequencer (wrms_ctrl).
`ifndef WINDOWED_RMS_CURRENT_METER_DEFINES_SVH
`define WINDOWED_RMS_CURRENT_METER_DEFINES_SVH
`ifndef SYNTHESIS
`define WRMS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wrms check failed");
`define WRMS_ASSERT_NEXT(label, trig, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
        else $error("wrms check failed");
`else
`define WRMS_ASSERT(label, prop)
`define WRMS_ASSERT_NEXT(label, trig, res)
`endif
`endif

[design/wrms_pkg.sv]
// Types, widths and constants of the windowed RMS current meter.
package wrms_pkg;

    localparam int ADC_BITS   = 12;
    localparam int COUNT_BITS = 24;

    localparam int SMP_BITS   = 12;
    localparam int SQ_BITS    = 2 * SMP_BITS;
    localparam int SUM_BITS   = 48;
    localparam int ROOT_BITS  = SUM_BITS / 2;
    localparam int TICK_BITS  = 20;
    localparam int GAIN_BITS  = 24;
    localparam int PROD_BITS  = ROOT_BITS + GAIN_BITS;
    localparam int RMS_BITS   = 12;
    localparam int MA_BITS    = 16;
    localparam int TOTAL_BITS = 24;
    localparam int STEP_BITS  = $clog2(SUM_BITS);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_POINT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_US  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_Q16   = 2'd2;

    localparam logic [SMP_BITS-1:0]  ZERO_POINT_RESET = 12'd2048;
    localparam logic [TICK_BITS-1:0] PERIOD_RESET     = 20'd20000;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET       = 24'd285468;

    localparam logic [SMP_BITS-1:0] SMP_MASK = SMP_BITS'((64'd1 << ADC_BITS) - 64'd1);

    localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(SUM_BITS - 1);
    localparam logic [STEP_BITS-1:0] ROOT_LAST = STEP_BITS'(ROOT_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_MUL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic root_step;
        logic mul_load;
        logic out_load;
        logic out_empty;
    } cmd_t;

    typedef struct packed {
        logic close_hit;
        logic empty;
    } status_t;

endpackage

[design/wrms_ctrl.sv]
// Sequencer for window close: divide, root, multiply and result handoff.
`include "windowed_rms_current_meter_defines.svh"

module wrms_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  wrms_pkg::status_t status,
    output wrms_pkg::cmd_t  ctrl
);
    import wrms_pkg::*;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold a closing tick while a close is in flight or a result waits
    assign in_stall  = status.close_hit & ((state_reg != ST_IDLE) | out_valid_reg);
    assign take      = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg & out_stall;
        ctrl           = '0;
        ctrl.take      = take;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && status.close_hit)
                begin
                    step_next = '0;
                    if (status.empty)
                    begin
                        ctrl.out_empty = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                ctrl.root_step = 1'b1;
                step_next      = step_reg + 1'b1;
                if (step_reg == ROOT_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_load = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                ctrl.out_load  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    `WRMS_ASSERT(a_close_only_when_free, (take && status.close_hit) |-> (state_reg == ST_IDLE && !out_valid_reg))
    `WRMS_ASSERT(a_result_source, $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT || ($past(take) && $past(status.empty))))
    `WRMS_ASSERT_NEXT(a_div_runs_full, (state_reg == ST_DIV && step_reg != DIV_LAST), (state_reg == ST_DIV))
    `WRMS_ASSERT_NEXT(a_emit_sets_valid, (state_reg == ST_EMIT), out_valid_reg)

endmodule

[design/wrms_datapath.sv]
// Accumulators, config registers, divider, root, gain multiply and result word.
module wrms_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [wrms_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [wrms_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  cmd,
    input  logic [wrms_pkg::SMP_BITS-1:0]         sample,
    input  wrms_pkg::cmd_t                        ctrl,
    output wrms_pkg::status_t                     status,
    output logic [wrms_pkg::RMS_BITS-1:0]         rms_counts,
    output logic [wrms_pkg::MA_BITS-1:0]          current_ma,
    output logic [wrms_pkg::TOTAL_BITS-1:0]       sample_total,
    output logic                                  empty_window,
    output logic                                  count_saturated
);
    import wrms_pkg::*;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

    // configuration
    logic [SMP_BITS-1:0]  zero_point_reg;
    logic [TICK_BITS-1:0] period_reg;
    logic [GAIN_BITS-1:0] gain_reg;

    // open window
    logic [SUM_BITS-1:0]   sum_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TICK_BITS-1:0]  ticks_reg;
    logic                  sat_reg;

    // closed window work
    logic [SUM_BITS-1:0]    quo_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [COUNT_BITS-1:0]  div_reg;
    logic                   sat_snap_reg;
    logic [ROOT_BITS+1:0]   sq_rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [PROD_BITS-1:0]   prod_reg;

    // result word
    logic [RMS_BITS-1:0]   rms_reg;
    logic [MA_BITS-1:0]    ma_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic                  empty_reg;
    logic                  csat_reg;

    logic [SMP_BITS-1:0]        s_m, z_m;
    logic signed [SMP_BITS:0]   diff;
    logic signed [SQ_BITS+1:0]  sq_full;
    logic [SQ_BITS-1:0]         sq;
    logic [SUM_BITS:0]          sum_add;
    logic [TICK_BITS-1:0]       ticks_p1;
    logic                       closing;

    logic [COUNT_BITS:0]        div_sh;
    logic                       div_ge;
    logic [ROOT_BITS+3:0]       rt_sh;
    logic [ROOT_BITS+3:0]       rt_trial;
    logic                       rt_ge;
    logic [32:0]                tot_ext;
    logic [TOTAL_BITS-1:0]      tot_sat;

    always_comb
    begin
        s_m      = sample & SMP_MASK;
        z_m      = zero_point_reg & SMP_MASK;
        diff     = $signed({1'b0, s_m}) - $signed({1'b0, z_m});
        sq_full  = diff * diff;
        sq       = sq_full[SQ_BITS-1:0];
        sum_add  = {1'b0, sum_reg} + (SUM_BITS + 1)'(sq);
        ticks_p1 = ticks_reg + 1'b1;
        closing  = cmd & (ticks_p1 >= period_reg);

        div_sh   = {rem_reg, quo_reg[SUM_BITS-1]};
        div_ge   = div_sh >= {1'b0, div_reg};

        rt_sh    = {sq_rem_reg, quo_reg[SUM_BITS-1:SUM_BITS-2]};
        rt_trial = (ROOT_BITS + 4)'({root_reg, 2'b01});
        rt_ge    = rt_sh >= rt_trial;

        tot_ext  = 33'(div_reg);
        tot_sat  = (tot_ext > 33'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_BITS-1:0];
    end

    assign status.close_hit = closing;
    assign status.empty     = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_point_reg <= ZERO_POINT_RESET;
            period_reg     <= PERIOD_RESET;
            gain_reg       <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ZERO_POINT: zero_point_reg <= cfg_data[SMP_BITS-1:0];
                REG_PERIOD_US:  period_reg     <= cfg_data[TICK_BITS-1:0];
                REG_GAIN_Q16:   gain_reg       <= cfg_data[GAIN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ticks_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (ctrl.take)
        begin
            if (!cmd)
            begin
                // drop the word once the count is full
                if (&count_reg)
                begin
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sum_reg   <= sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (closing)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ticks_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else
            begin
                ticks_reg <= ticks_p1;
            end
        end
    end

    // quo_reg holds dividend, then quotient, then feeds the root two bits a step
    always_ff @(posedge clk)
    begin
        if (ctrl.take && closing)
        begin
            quo_reg      <= sum_reg;
            div_reg      <= count_reg;
            sat_snap_reg <= sat_reg;
            rem_reg      <= '0;
            sq_rem_reg   <= '0;
            root_reg     <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= div_ge ? COUNT_BITS'(div_sh - {1'b0, div_reg}) : div_sh[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], div_ge};
        end
        else if (ctrl.root_step)
        begin
            sq_rem_reg <= rt_ge ? (ROOT_BITS + 2)'(rt_sh - rt_trial) : rt_sh[ROOT_BITS+1:0];
            root_reg   <= {root_reg[ROOT_BITS-2:0], rt_ge};
            quo_reg    <= {quo_reg[SUM_BITS-3:0], 2'b00};
        end
        if (ctrl.mul_load)
        begin
            prod_reg <= root_reg * gain_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_empty)
        begin
            rms_reg   <= '0;
            ma_reg    <= '0;
            total_reg <= '0;
            empty_reg <= 1'b1;
            csat_reg  <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            rms_reg   <= (|root_reg[ROOT_BITS-1:RMS_BITS]) ? '1 : root_reg[RMS_BITS-1:0];
            ma_reg    <= (|prod_reg[PROD_BITS-1:16+MA_BITS]) ? '1 : prod_reg[16+MA_BITS-1:16];
            total_reg <= tot_sat;
            empty_reg <= 1'b0;
            csat_reg  <= sat_snap_reg;
        end
    end

    assign rms_counts      = rms_reg;
    assign current_ma      = ma_reg;
    assign sample_total    = total_reg;
    assign empty_window    = empty_reg;
    assign count_saturated = csat_reg;

endmodule

[design/windowed_rms_current_meter.sv]
// Windowed RMS current meter: top level joining sequencer and datapath.
// Every sample or tick word is taken in the cycle it is offered unless stalled.
// A tick that closes the window starts a run in the background: the one-bit-a-
// cycle restoring divider (sum over count), the two-bits-a-cycle square root,
// the gain multiply and the loading of the result, in that order.
// Samples and ticks keep flowing into the fresh window during that run; only
// a further closing tick is stalled until the run ends and the previous result
// has been taken. An empty window gives its flagged result at the closing tick.
module windowed_rms_current_meter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [wrms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wrms_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [wrms_pkg::SMP_BITS-1:0]      sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [wrms_pkg::RMS_BITS-1:0]      rms_counts,
    output logic [wrms_pkg::MA_BITS-1:0]       current_ma,
    output logic [wrms_pkg::TOTAL_BITS-1:0]    sample_total,
    output logic                               empty_window,
    output logic                               count_saturated
);
    import wrms_pkg::*;

    cmd_t    ctrl;
    status_t status;

    wrms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    wrms_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .sample          (sample),
        .ctrl            (ctrl),
        .status          (status),
        .rms_counts      (rms_counts),
        .current_ma      (current_ma),
        .sample_total    (sample_total),
        .empty_window    (empty_window),
        .count_saturated (count_saturated)
    );

endmodule

[dv/tb_windowed_rms_current_meter.sv]
// Self-checking testbench for the windowed RMS current meter.
module tb_windowed_rms_current_meter;
    timeunit 1ns;
    timeprecision 1ps;
    import wrms_pkg::*;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD     = 400;
    localparam int LIMIT_CYCLES  = 1500000;

    typedef struct packed {
        logic [RMS_BITS-1:0]   rms;
        logic [MA_BITS-1:0]    ma;
        logic [TOTAL_BITS-1:0] total;
        logic                  empty;
        logic                  sat;
    } reading_t;

    class rms_scoreboard;
        logic [SMP_BITS-1:0]   zero_point;
        logic [TICK_BITS-1:0]  period_us;
        logic [GAIN_BITS-1:0]  gain_q16;
        logic [SUM_BITS-1:0]   square_sum;
        logic [COUNT_BITS-1:0] sample_count;
        logic [TICK_BITS-1:0]  elapsed_ticks;
        logic                  dropped;
        reading_t              due_q[$];
        int                    errors;

        function new();
            zero_point    = ZERO_POINT_RESET;
            period_us     = PERIOD_RESET;
            gain_q16      = GAIN_RESET;
            square_sum    = '0;
            sample_count  = '0;
            elapsed_ticks = '0;
            dropped       = 1'b0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_ZERO_POINT: zero_point = data[SMP_BITS-1:0];
                REG_PERIOD_US:  period_us  = data[TICK_BITS-1:0];
                REG_GAIN_Q16:   gain_q16   = data[GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [ROOT_BITS-1:0] int_root(logic [SUM_BITS-1:0] v);
            logic [ROOT_BITS-1:0] r;
            logic [SUM_BITS-1:0]  t;
            r = '0;
            for (int b = ROOT_BITS - 1; b >= 0; b--) begin
                t = {{ROOT_BITS{1'b0}}, r};
                t[b] = 1'b1;
                if (t * t <= v)
                    r[b] = 1'b1;
            end
            return r;
        endfunction

        function void note_word(logic c, logic [SMP_BITS-1:0] s);
            int                   offset;
            logic [SUM_BITS:0]    grown;
            logic [SUM_BITS:0]    sq;
            logic [SUM_BITS-1:0]  mean;
            logic [ROOT_BITS-1:0] root;
            logic [PROD_BITS-1:0] prod;
            reading_t             r;
            if (c == CMD_SAMPLE) begin
                offset = int'(s & SMP_MASK) - int'(zero_point & SMP_MASK);
                if (sample_count == '1) begin
                    dropped = 1'b1;
                end
                else begin
                    sq = offset * offset;
                    grown = {1'b0, square_sum} + sq;
                    square_sum = grown[SUM_BITS] ? '1 : grown[SUM_BITS-1:0];
                    sample_count++;
                end
                return;
            end
            elapsed_ticks++;
            if (elapsed_ticks < period_us)
                return;
            if (sample_count == 0) begin
                r = '0;
                r.empty = 1'b1;
            end
            else begin
                mean = square_sum / {{(SUM_BITS-COUNT_BITS){1'b0}}, sample_count};
                root = int_root(mean);
                prod = {{GAIN_BITS{1'b0}}, root} * {{ROOT_BITS{1'b0}}, gain_q16};
                r.rms   = (root > 4095) ? '1 : root[RMS_BITS-1:0];
                r.ma    = (prod[PROD_BITS-1:16] > 65535) ? '1 : prod[31:16];
                r.total = sample_count;
                r.empty = 1'b0;
                r.sat   = dropped;
            end
            due_q.push_back(r);
            square_sum    = '0;
            sample_count  = '0;
            elapsed_ticks = '0;
            dropped       = 1'b0;
        endfunction

        function void compare(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected word rms_counts %0d current_ma %0d sample_total %0d",
                         $time, got.rms, got.ma, got.total);
                errors++;
                return;
            end
            want = due_q.pop_front();
            compare("rms_counts", want.rms, got.rms);
            compare("current_ma", want.ma, got.ma);
            compare("sample_total", want.total, got.total);
            compare("empty_window", want.empty, got.empty);
            compare("count_saturated", want.sat, got.sat);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = 1'b0;
    logic [SMP_BITS-1:0]      sample = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [RMS_BITS-1:0]      rms_counts;
    logic [MA_BITS-1:0]       current_ma;
    logic [TOTAL_BITS-1:0]    sample_total;
    logic                     empty_window;
    logic                     count_saturated;

    rms_scoreboard meter;
    int            tx_gap_pct = 0;
    int            rx_stall_pct = 0;
    bit            long_hold_req = 1'b0;
    int            cycles = 0;

    windowed_rms_current_meter dut (.*);

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    // Receiver: random stalls, plus one long hold on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else begin
                if (stall_left == 0)
                    stall_left = pick_gap(rx_stall_pct);
                out_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            meter.check_reading('{rms_counts, current_ma, sample_total, empty_window,
                                  count_saturated});
    end

    // Offer one word and hold it until taken; valid stays high for back-to-back words.
    task automatic send_word(logic c, logic [SMP_BITS-1:0] s);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        meter.note_word(c, s);
    endtask

    task automatic quiet_input();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (meter.due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        meter.write_reg(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int                       random_sent;
        int                       phase;
        int                       phase_len;
        int                       tick_pct;
        logic [CFG_DATA_BITS-1:0] data;
        meter = new();
        random_sent  = 0;
        phase        = 0;
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: samples go into the long default window
        send_word(CMD_SAMPLE, 12'd0);
        send_word(CMD_SAMPLE, 12'd4095);
        send_word(CMD_SAMPLE, 12'd2048);
        send_word(CMD_SAMPLE, 12'd2047);
        quiet_input();
        wait_idle();
        set_reg(REG_SPARE, '1);
        set_reg(REG_PERIOD_US, 24'd1);
        send_word(CMD_TICK, 12'($urandom()));
        send_word(CMD_TICK, 12'($urandom()));

        // full-scale offset with maximum gain: current saturates
        quiet_input();
        wait_idle();
        set_reg(REG_ZERO_POINT, 24'd0);
        set_reg(REG_GAIN_Q16, '1);
        send_word(CMD_SAMPLE, 12'd4095);
        send_word(CMD_SAMPLE, 12'd4095);
        send_word(CMD_TICK, 12'($urandom()));

        // top zero point with junk in the upper data bits, zero gain
        quiet_input();
        wait_idle();
        set_reg(REG_ZERO_POINT, '1);
        set_reg(REG_GAIN_Q16, 24'd0);
        send_word(CMD_SAMPLE, 12'd0);
        send_word(CMD_SAMPLE, 12'd1);
        send_word(CMD_TICK, 12'($urandom()));

        // period of zero closes on the first tick
        quiet_input();
        wait_idle();
        set_reg(REG_PERIOD_US, 24'hF00000);
        set_reg(REG_ZERO_POINT, 24'd2048);
        set_reg(REG_GAIN_Q16, 24'd65536);
        send_word(CMD_SAMPLE, 12'd100);
        send_word(CMD_TICK, 12'($urandom()));
        send_word(CMD_TICK, 12'($urandom()));

        // a long period, then lowered to the count of ticks already seen
        quiet_input();
        wait_idle();
        set_reg(REG_PERIOD_US, 24'd1000000);
        send_word(CMD_SAMPLE, 12'd2000);
        send_word(CMD_TICK, 12'($urandom()));
        send_word(CMD_SAMPLE, 12'd3000);
        send_word(CMD_TICK, 12'($urandom()));
        quiet_input();
        wait_idle();
        set_reg(REG_PERIOD_US, 24'd2);
        send_word(CMD_TICK, 12'($urandom()));

        // window closes exactly on the period
        quiet_input();
        wait_idle();
        set_reg(REG_PERIOD_US, 24'd3);
        set_reg(REG_GAIN_Q16, 24'(GAIN_RESET));
        send_word(CMD_SAMPLE, 12'd1000);
        send_word(CMD_TICK, 12'($urandom()));
        send_word(CMD_TICK, 12'($urandom()));
        send_word(CMD_TICK, 12'($urandom()));

        while (random_sent < RANDOM_ITEMS) begin
            phase++;
            quiet_input();
            wait_idle();
            data = 24'($urandom());
            case ($urandom_range(5))
                0: data[SMP_BITS-1:0] = '0;
                1: data[SMP_BITS-1:0] = '1;
                default: ;
            endcase
            set_reg(REG_ZERO_POINT, data);
            data = 24'($urandom());
            case ($urandom_range(11))
                0:       data[TICK_BITS-1:0] = '0;
                1, 2:    data[TICK_BITS-1:0] = 20'd1;
                default: data[TICK_BITS-1:0] = 20'($urandom_range(24, 2));
            endcase
            if (phase == 2)
                data[TICK_BITS-1:0] = 20'd1;
            set_reg(REG_PERIOD_US, data);
            case ($urandom_range(7))
                0:       data = '0;
                1:       data = '1;
                2, 3:    data = 24'($urandom());
                default: data = 24'($urandom_range(400000, 20000));
            endcase
            set_reg(REG_GAIN_Q16, data);

            tx_gap_pct   = 20 * $urandom_range(2);
            rx_stall_pct = 20 * $urandom_range(2);
            tick_pct     = $urandom_range(50, 8);
            phase_len    = $urandom_range(160, 40);
            // back up the output so closing ticks stall the input
            if (phase == 2) begin
                tick_pct      = 60;
                tx_gap_pct    = 0;
                long_hold_req = 1'b1;
            end

            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(99) < tick_pct) begin
                    send_word(CMD_TICK, 12'($urandom()));
                end
                else begin
                    case ($urandom_range(9))
                        0:       send_word(CMD_SAMPLE, '0);
                        1:       send_word(CMD_SAMPLE, '1);
                        2, 3:    send_word(CMD_SAMPLE,
                                           meter.zero_point + 12'($urandom_range(16)) - 12'd8);
                        default: send_word(CMD_SAMPLE, 12'($urandom()));
                    endcase
                end
            end
            random_sent += phase_len;
        end

        quiet_input();
        wait_idle();
        if (meter.errors == 0 && meter.due_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/wrms_pkg.sv
design/wrms_ctrl.sv
design/wrms_datapath.sv
design/windowed_rms_current_meter.sv
dv/tb_windowed_rms_current_meter.sv
